// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the game-port register RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gpm_pkg.sv -----
// Package: types and constants of the game-port mouse and pot registers.
`timescale 1ns / 1ps
package gpm_pkg;

  typedef enum logic [2:0] {
    OP_MOVE     = 3'd0,
    OP_RD_PORT0 = 3'd1,
    OP_RD_PORT1 = 3'd2,
    OP_TEST_WR  = 3'd3,
    OP_POT_WR   = 3'd4,
    OP_POT_STAT = 3'd5,
    OP_POT_CNT  = 3'd6,
    OP_SAMPLE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    CFG_CLAMP_MODE = 2'd0,
    CFG_LIMIT_X    = 2'd1,
    CFG_LIMIT_Y    = 2'd2
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] LIMIT_RESET    = 16'hFFFF;
  localparam logic [7:0]  SAT_POS        = 8'h7F;
  localparam logic [7:0]  SAT_NEG        = 8'h81;
  localparam logic [31:0] DELTA_POS_MAX  = 32'h0000_007F;
  localparam logic [31:0] DELTA_NEG_MIN  = 32'hFFFF_FF81;
  localparam logic [7:0]  CNT_TEST_MASK  = 8'hFC;
  localparam logic [15:0] POT_ODD_MASK   = 16'h5500;
  localparam logic [15:0] POT_EVEN_MASK  = 16'hAA00;
  localparam logic [15:0] POT_CLR_P0B1   = 16'hFBFF;
  localparam logic [15:0] POT_CLR_P0B2   = 16'hFEFF;
  localparam logic [15:0] POT_CLR_P1B1   = 16'hBFFF;
  localparam logic [15:0] POT_CLR_P1B2   = 16'hEFFF;
  localparam logic [15:0] POT_HI_STEP    = 16'h0100;

  typedef struct packed {
    op_t                op;
    logic               axis;
    logic signed [15:0] move_amount;
    logic               is_absolute;
    logic [15:0]        write_value;
    logic [15:0]        port0_dir;
    logic [2:0]         port0_buttons;
    logic [15:0]        port1_dir;
    logic [2:0]         port1_buttons;
  } item_t;

  // Handoff from execute stage to result register.
  typedef struct packed {
    logic        valid;
    logic [15:0] data;
  } res_word_t;

endpackage

// ----- rtl/core/gpm_if.sv -----
// Interfaces: input word channel and result word channel.
`timescale 1ns / 1ps
interface gpm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic               axis;
  logic signed [15:0] move_amount;
  logic               is_absolute;
  logic [15:0]        write_value;
  logic [15:0]        port0_dir;
  logic [2:0]         port0_buttons;
  logic [15:0]        port1_dir;
  logic [2:0]         port1_buttons;

  modport source (output valid, op, axis, move_amount, is_absolute, write_value,
                  port0_dir, port0_buttons, port1_dir, port1_buttons,
                  input ready);
  modport sink (input valid, op, axis, move_amount, is_absolute, write_value,
                port0_dir, port0_buttons, port1_dir, port1_buttons,
                output ready);
endinterface

interface gpm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ----- rtl/core/gpm_in_reg.sv -----
// Input register: captures one input word ahead of the execute stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpm_in_reg (
  input  logic          clk,
  input  logic          rst,
  gpm_in_if.sink        src,
  input  logic          advance,
  output logic          stage_valid,
  output gpm_pkg::item_t stage
);
  import gpm_pkg::*;

  logic load;

  assign src.ready = !stage_valid || advance;
  assign load      = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src.ready) begin
      stage_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.op            <= op_t'(src.op);
      stage.axis          <= src.axis;
      stage.move_amount   <= src.move_amount;
      stage.is_absolute   <= src.is_absolute;
      stage.write_value   <= src.write_value;
      stage.port0_dir     <= src.port0_dir;
      stage.port0_buttons <= src.port0_buttons;
      stage.port1_dir     <= src.port1_dir;
      stage.port1_buttons <= src.port1_buttons;
    end
  end

  `ASSERT_NEXT(a_stage_hold, stage_valid && !advance, stage_valid && $stable(stage),
               "held input word changed while stalled")

endmodule

// ----- rtl/core/gpm_core.sv -----
// Execute stage: mouse position, counters, pot and joystick registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpm_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           fire,
  input  gpm_pkg::item_t                 item,
  output gpm_pkg::res_word_t             res
);
  import gpm_pkg::*;

  logic        clamp_mode;
  logic [15:0] limit_x, limit_y;
  logic [31:0] pos_x, pos_y, sampled_x, sampled_y;
  logic [7:0]  count_x, count_y;
  logic [15:0] pot_control, pot_count;
  logic [15:0] dir0_reg, dir1_reg;
  logic [2:0]  btn0_reg, btn1_reg;

  logic [31:0] amt_ext, pos_sel, sum, clamped, move_new;
  logic [15:0] lim_sel;
  logic [31:0] dx, dy;
  logic [7:0]  sat_x, sat_y, count_x_rd, count_y_rd;
  logic [15:0] rd_port0, pot_stat, pc_lo, pot_count_next;
  logic [15:0] result;

  function automatic logic [7:0] sat_delta(input logic [31:0] d);
    logic [7:0] s;
    if (d[31]) begin
      s = (d < DELTA_NEG_MIN) ? SAT_NEG : d[7:0];
    end else begin
      s = (d > DELTA_POS_MAX) ? SAT_POS : d[7:0];
    end
    return s;
  endfunction

  always_comb begin
    amt_ext = {{16{item.move_amount[15]}}, item.move_amount};
    pos_sel = item.axis ? pos_y : pos_x;
    lim_sel = item.axis ? limit_y : limit_x;
    sum     = pos_sel + amt_ext;
    if (sum[31]) begin
      clamped = '0;
    end else if (sum >= {16'd0, lim_sel}) begin
      clamped = (lim_sel == 16'd0) ? '0 : {16'd0, lim_sel - 16'd1};
    end else begin
      clamped = sum;
    end
    if (clamp_mode) begin
      move_new = item.is_absolute ? amt_ext : clamped;
    end else begin
      move_new = sum;
    end
  end

  always_comb begin
    dx         = pos_x - sampled_x;
    dy         = pos_y - sampled_y;
    sat_x      = sat_delta(dx);
    sat_y      = sat_delta(dy);
    count_x_rd = count_x + sat_x;
    count_y_rd = count_y + sat_y;
    rd_port0   = {count_y_rd, count_x_rd} + dir0_reg;
  end

  always_comb begin
    pot_stat = ((pot_control | (pot_control >> 1)) & POT_ODD_MASK)
             | ((~pot_control & POT_EVEN_MASK) >> 1);
    if (btn0_reg[1]) pot_stat = pot_stat & POT_CLR_P0B1;
    if (btn0_reg[2]) pot_stat = pot_stat & POT_CLR_P0B2;
    if (btn1_reg[1]) pot_stat = pot_stat & POT_CLR_P1B1;
    if (btn1_reg[2]) pot_stat = pot_stat & POT_CLR_P1B2;
    // low byte wraps on its own
    pc_lo = btn0_reg[1] ? {pot_count[15:8], pot_count[7:0] + 8'd1} : pot_count;
    pot_count_next = btn0_reg[2] ? pc_lo + POT_HI_STEP : pc_lo;
  end

  always_comb begin
    case (item.op)
      OP_RD_PORT0: result = rd_port0;
      OP_RD_PORT1: result = dir1_reg;
      OP_POT_STAT: result = pot_stat;
      OP_POT_CNT:  result = pot_count_next;
      default:     result = '0;
    endcase
  end

  assign res.valid = fire;
  assign res.data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_mode  <= 1'b0;
      limit_x     <= LIMIT_RESET;
      limit_y     <= LIMIT_RESET;
      pos_x       <= '0;
      pos_y       <= '0;
      sampled_x   <= '0;
      sampled_y   <= '0;
      count_x     <= '0;
      count_y     <= '0;
      pot_control <= '0;
      pot_count   <= '0;
      dir0_reg    <= '0;
      dir1_reg    <= '0;
      btn0_reg    <= '0;
      btn1_reg    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLAMP_MODE: clamp_mode <= cfg_data[0];
        CFG_LIMIT_X:    limit_x    <= cfg_data;
        CFG_LIMIT_Y:    limit_y    <= cfg_data;
        default: ;
      endcase
    end else if (fire) begin
      case (item.op)
        OP_MOVE: begin
          if (item.axis) pos_y <= move_new;
          else           pos_x <= move_new;
        end
        OP_RD_PORT0: begin
          count_x   <= count_x_rd;
          count_y   <= count_y_rd;
          sampled_x <= pos_x;
          sampled_y <= pos_y;
        end
        OP_TEST_WR: begin
          count_x <= (count_x & ~CNT_TEST_MASK) | (item.write_value[7:0] & CNT_TEST_MASK);
          count_y <= (count_y & ~CNT_TEST_MASK) | (item.write_value[15:8] & CNT_TEST_MASK);
        end
        OP_POT_WR:  pot_control <= item.write_value;
        OP_POT_CNT: pot_count   <= pot_count_next;
        OP_SAMPLE: begin
          dir0_reg <= item.port0_dir;
          btn0_reg <= item.port0_buttons;
          dir1_reg <= item.port1_dir;
          btn1_reg <= item.port1_buttons;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEXT(a_test_wr, fire && item.op == OP_TEST_WR,
               count_x[7:2] == $past(item.write_value[7:2]) &&
               count_y[7:2] == $past(item.write_value[15:10]),
               "test write did not set counter high bits")
  `ASSERT_IMPL(a_rd_port1, fire && item.op == OP_RD_PORT1, res.data == dir1_reg,
               "port 1 read does not return direction word")
  `ASSERT_NEXT(a_sample_sync, fire && item.op == OP_RD_PORT0,
               sampled_x == pos_x && sampled_y == pos_y,
               "sampled position not taken on port 0 read")

endmodule

// ----- rtl/core/gpm_out_reg.sv -----
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpm_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  gpm_pkg::res_word_t res,
  gpm_out_if.source          dst,
  output logic               free
);
  import gpm_pkg::*;

  assign free = !dst.valid || dst.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (free) begin
      dst.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && free) begin
      dst.read_data <= res.data;
    end
  end

  `ASSERT_IMPL(a_no_overwrite, res.valid, free,
               "result word arrived while result register is blocked")

endmodule

// ----- rtl/core/game_port_mouse_pot_registers.sv -----
// Top level: game-port mouse and pot register block.
`timescale 1ns / 1ps
// Takes one input word per cycle unless the result side stalls, and returns
// exactly one result word for each. The word is registered at acceptance and
// executed against the register state once the result register is free; its
// result word is loaded into the output register as the word executes.
// Throughput is set by the single execute stage and is one word per clock as
// long as results are taken; a stalled result register holds the input side
// after one more word. Configuration writes take effect at the write edge and
// are meant for idle periods.
module game_port_mouse_pot_registers (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpm_pkg::CFG_DATA_W-1:0] cfg_data,
  gpm_in_if.sink                         items,
  gpm_out_if.source                      results
);
  import gpm_pkg::*;

  logic      advance;
  logic      stage_valid;
  item_t     stage;
  res_word_t res;

  gpm_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .src         (items),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  gpm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (stage_valid && advance),
    .item      (stage),
    .res       (res)
  );

  gpm_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .res  (res),
    .dst  (results),
    .free (advance)
  );

endmodule

// ----- test/testbench.sv -----
// Testbench: directed and random words through the game-port register block.
`timescale 1ns / 1ps
module testbench;
  import gpm_pkg::*;

  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         IDLE_PCT    = 38;
  localparam int         RAND_PHASES = 6;
  localparam int         PHASE_WORDS = 85;

  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    item_t       w;
    bit          typed;
    logic [15:0] want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gpm_in_if  items_ch();
  gpm_out_if results_ch();

  game_port_mouse_pot_registers uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .results   (results_ch)
  );

  // predictor copy of the block
  logic        clamp_on;
  logic [15:0] lim_x, lim_y;
  logic [31:0] cur_x, cur_y, snap_x, snap_y;
  logic [7:0]  cnt_x, cnt_y;
  logic [15:0] pot_ctl, pot_cnt, joy0_dir, joy1_dir;
  logic [2:0]  joy0_btn, joy1_btn;

  logic [15:0] expected_data[$];
  logic [15:0] head_word;
  int          errors = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          hold_left = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] clamped_move(logic [31:0] p0, logic [31:0] step,
                                               logic [15:0] lim);
    logic [31:0] p;
    p = p0 + step;
    if (p[31]) return '0;
    if (p >= {16'h0, lim}) return (lim == 16'h0) ? '0 : {16'h0, lim} - 32'd1;
    return p;
  endfunction

  // saturated mouse step, low byte only matters to the counters
  function automatic logic [7:0] mouse_delta(logic [31:0] now, logic [31:0] last);
    logic [31:0] d;
    d = now - last;
    if (d[31]) return (d < DELTA_NEG_MIN) ? DELTA_NEG_MIN[7:0] : d[7:0];
    return (d > DELTA_POS_MAX) ? DELTA_POS_MAX[7:0] : d[7:0];
  endfunction

  function automatic logic [15:0] predict_word(item_t w);
    logic [31:0] step;
    logic [15:0] r;
    step = {{16{w.move_amount[15]}}, w.move_amount};
    r = '0;
    case (w.op)
      OP_MOVE: begin
        if (clamp_on && w.is_absolute) begin
          if (w.axis) cur_y = step;
          else cur_x = step;
        end else if (clamp_on) begin
          if (w.axis) cur_y = clamped_move(cur_y, step, lim_y);
          else cur_x = clamped_move(cur_x, step, lim_x);
        end else begin
          if (w.axis) cur_y = cur_y + step;
          else cur_x = cur_x + step;
        end
      end
      OP_RD_PORT0: begin
        cnt_x = cnt_x + mouse_delta(cur_x, snap_x);
        cnt_y = cnt_y + mouse_delta(cur_y, snap_y);
        snap_x = cur_x;
        snap_y = cur_y;
        r = {8'h0, cnt_x} + {cnt_y, 8'h0} + joy0_dir;
      end
      OP_RD_PORT1: r = joy1_dir;
      OP_TEST_WR: begin
        cnt_x = (cnt_x & ~CNT_TEST_MASK) | (w.write_value[7:0] & CNT_TEST_MASK);
        cnt_y = (cnt_y & ~CNT_TEST_MASK) | (w.write_value[15:8] & CNT_TEST_MASK);
      end
      OP_POT_WR: pot_ctl = w.write_value;
      OP_POT_STAT: begin
        r = ((pot_ctl | (pot_ctl >> 1)) & POT_ODD_MASK) | ((~pot_ctl & POT_EVEN_MASK) >> 1);
        if (joy0_btn[1]) r = r & POT_CLR_P0B1;
        if (joy0_btn[2]) r = r & POT_CLR_P0B2;
        if (joy1_btn[1]) r = r & POT_CLR_P1B1;
        if (joy1_btn[2]) r = r & POT_CLR_P1B2;
      end
      OP_POT_CNT: begin
        if (joy0_btn[1]) pot_cnt[7:0] = pot_cnt[7:0] + 8'd1;
        if (joy0_btn[2]) pot_cnt = pot_cnt + POT_HI_STEP;
        r = pot_cnt;
      end
      OP_SAMPLE: begin
        joy0_dir = w.port0_dir;
        joy0_btn = w.port0_buttons;
        joy1_dir = w.port1_dir;
        joy1_btn = w.port1_buttons;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t word_row(op_t op, logic ax, logic [15:0] amt, logic ab,
                                         logic [15:0] wv, bit typed, logic [15:0] want);
    stim_row_t row;
    row = '{default: '0};
    row.w.op = op;
    row.w.axis = ax;
    row.w.move_amount = amt;
    row.w.is_absolute = ab;
    row.w.write_value = wv;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t sample_row(logic [15:0] d0, logic [2:0] b0,
                                           logic [15:0] d1, logic [2:0] b1);
    stim_row_t row;
    row = '{default: '0};
    row.w.op = OP_SAMPLE;
    row.w.port0_dir = d0;
    row.w.port0_buttons = b0;
    row.w.port1_dir = d1;
    row.w.port1_buttons = b1;
    row.typed = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [1:0] idx, logic [15:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s: read_data %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_word(item_t w, bit typed, logic [15:0] want);
    logic [15:0] pred;
    @(negedge clk);
    while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.op            <= w.op;
    items_ch.axis          <= w.axis;
    items_ch.move_amount   <= w.move_amount;
    items_ch.is_absolute   <= w.is_absolute;
    items_ch.write_value   <= w.write_value;
    items_ch.port0_dir     <= w.port0_dir;
    items_ch.port0_buttons <= w.port0_buttons;
    items_ch.port1_dir     <= w.port1_dir;
    items_ch.port1_buttons <= w.port1_buttons;
    items_ch.valid         <= 1'b1;
    do @(posedge clk); while (!items_ch.ready);
    pred = predict_word(w);
    expected_data.push_back(typed ? want : pred);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    items_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_data.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_CLAMP_MODE: clamp_on = val[0];
      CFG_LIMIT_X:    lim_x = val;
      CFG_LIMIT_Y:    lim_y = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: ready pattern, with one long hold-off
  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        results_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        results_ch.ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (expected_data.size() == 0) begin
        report_mismatch("unexpected result word", results_ch.read_data, 'x);
      end else begin
        head_word = expected_data.pop_front();
        if (results_ch.read_data !== head_word)
          report_mismatch("read_data mismatch", results_ch.read_data, head_word);
        results_checked++;
      end
    end
  end

  initial begin
    stim_row_t   rows[$];
    item_t       w;
    int          pick;
    logic        cm;
    logic [15:0] lx, ly;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_ch.valid = 1'b0;
    items_ch.op = '0;
    items_ch.axis = 1'b0;
    items_ch.move_amount = '0;
    items_ch.is_absolute = 1'b0;
    items_ch.write_value = '0;
    items_ch.port0_dir = '0;
    items_ch.port0_buttons = '0;
    items_ch.port1_dir = '0;
    items_ch.port1_buttons = '0;

    clamp_on = 1'b0;
    lim_x = LIMIT_RESET;
    lim_y = LIMIT_RESET;
    cur_x = '0;
    cur_y = '0;
    snap_x = '0;
    snap_y = '0;
    cnt_x = '0;
    cnt_y = '0;
    pot_ctl = '0;
    pot_cnt = '0;
    joy0_dir = '0;
    joy1_dir = '0;
    joy0_btn = '0;
    joy1_btn = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset state reads
    rows.push_back(word_row(OP_RD_PORT0, 0, 16'h0000, 0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_RD_PORT1, 0, 16'h0000, 0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_POT_STAT, 0, 16'h0000, 0, 16'h0000, 1, 16'h5500));
    rows.push_back(word_row(OP_POT_CNT,  0, 16'h0000, 0, 16'h0000, 1, 16'h0000));
    // extreme steps, absolute flag ignored without clamp
    rows.push_back(word_row(OP_MOVE, 0, 16'h7FFF, 0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 1, 16'h8000, 0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 0, 16'hFFFF, 1, 16'h0000, 1, 16'h0000));
    rows.push_back(sample_row(16'hFFFF, 3'd7, 16'hFFFF, 3'd7));
    rows.push_back(word_row(OP_RD_PORT0, 0, 16'h0000, 0, 16'h0000, 0, 16'h0000));
    rows.push_back(word_row(OP_RD_PORT1, 0, 16'h0000, 0, 16'h0000, 1, 16'hFFFF));
    rows.push_back(word_row(OP_POT_WR,   0, 16'h0000, 0, 16'hFFFF, 1, 16'h0000));
    rows.push_back(word_row(OP_POT_STAT, 0, 16'h0000, 0, 16'h0000, 0, 16'h0000));
    rows.push_back(word_row(OP_POT_CNT,  0, 16'h0000, 0, 16'h0000, 0, 16'h0000));
    rows.push_back(word_row(OP_TEST_WR,  0, 16'h0000, 0, 16'hFFFF, 1, 16'h0000));
    rows.push_back(word_row(OP_RD_PORT0, 0, 16'h0000, 0, 16'h0000, 0, 16'h0000));
    rows.push_back(sample_row(16'h0000, 3'd0, 16'h0000, 3'd0));
    rows.push_back(word_row(OP_POT_WR,   0, 16'h0000, 0, 16'h5A5A, 1, 16'h0000));
    rows.push_back(word_row(OP_POT_STAT, 0, 16'h0000, 0, 16'h0000, 0, 16'h0000));
    // clamp mode, zero vertical limit, unused register index
    rows.push_back(reg_row(CFG_CLAMP_MODE, 16'h0001));
    rows.push_back(reg_row(CFG_LIMIT_X, 16'd100));
    rows.push_back(reg_row(CFG_LIMIT_Y, 16'h0000));
    rows.push_back(reg_row(CFG_UNUSED, 16'hFFFF));
    rows.push_back(word_row(OP_MOVE, 0, 16'd500,  0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 1, 16'd5,    0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 0, 16'hFFFB, 1, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 1, 16'h7FFF, 1, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_RD_PORT0, 0, 16'h0000, 0, 16'h0000, 0, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 0, 16'd10,   0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_MOVE, 0, 16'hFFEC, 0, 16'h0000, 1, 16'h0000));
    rows.push_back(word_row(OP_RD_PORT0, 0, 16'h0000, 0, 16'h0000, 0, 16'h0000));

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        drain_results();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_word(rows[i].w, rows[i].typed, rows[i].want);
      end
    end
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          cm = 1'b0; lx = 16'hFFFF; ly = 16'hFFFF;
        end
        1: begin
          cm = 1'b1; lx = 16'hFFFF; ly = 16'hFFFF;
        end
        2: begin
          cm = 1'b1; lx = 16'($urandom_range(400, 1)); ly = 16'($urandom_range(400, 1));
        end
        3: begin
          cm = 1'b1; lx = 16'd1; ly = 16'd1;
        end
        4: begin
          cm = 1'b0; lx = 16'($urandom); ly = 16'($urandom);
        end
        default: begin
          cm = 1'b1; lx = 16'($urandom_range(65535, 1)); ly = 16'($urandom_range(65535, 1));
        end
      endcase
      // phase 4 runs with no idling on either side
      sender_idles = (ph != 4);
      receiver_idles = (ph != 4);
      write_reg(CFG_CLAMP_MODE, {15'h0, cm});
      write_reg(CFG_LIMIT_X, lx);
      write_reg(CFG_LIMIT_Y, ly);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) w.op = OP_MOVE;
        else if (pick < 50) w.op = OP_RD_PORT0;
        else if (pick < 57) w.op = OP_RD_PORT1;
        else if (pick < 64) w.op = OP_TEST_WR;
        else if (pick < 71) w.op = OP_POT_WR;
        else if (pick < 79) w.op = OP_POT_STAT;
        else if (pick < 87) w.op = OP_POT_CNT;
        else w.op = OP_SAMPLE;
        w.axis = 1'($urandom_range(1));
        w.is_absolute = 1'($urandom_range(1));
        if ($urandom_range(99) < 70) w.move_amount = 16'($urandom_range(600) - 300);
        else w.move_amount = 16'($urandom);
        w.write_value = 16'($urandom);
        w.port0_dir = 16'($urandom);
        w.port0_buttons = 3'($urandom);
        w.port1_dir = 16'($urandom);
        w.port1_buttons = 3'($urandom);
        send_word(w, 1'b0, '0);
        if (ph == 5 && n == 10) hold_left = 80;
        if (ph == 2 && n == 40) drain_results();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (expected_data.size() != 0)
      report_mismatch("result words never arrived", 'x, expected_data[0]);

    $display("Sent %0d words: directed reset/extreme/clamp cases, then %0d random phases",
             words_sent, RAND_PHASES);
    $display("across clamp on/off and limits 0..65535; %0d result words checked, %0d errors.",
             results_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/gpm_pkg.sv
rtl/core/gpm_if.sv
rtl/core/gpm_in_reg.sv
rtl/core/gpm_core.sv
rtl/core/gpm_out_reg.sv
rtl/core/game_port_mouse_pot_registers.sv
test/testbench.sv
